// ----- hdl/rcc_pkg.sv -----
package rcc_pkg;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	localparam logic [5:0] SEC_MAX   = 6'd59;
	localparam logic [5:0] MIN_MAX   = 6'd59;
	localparam logic [4:0] HOUR_MAX  = 5'd23;
	localparam logic [3:0] MONTH_MAX = 4'd12;
	localparam logic [6:0] YEAR_MAX  = 7'd99;

	// packed so that second sits in the lowest bits
	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} rcc_time_t;

	typedef enum logic [2:0] {
		LVL_SECOND = 3'd0,
		LVL_MINUTE = 3'd1,
		LVL_HOUR   = 3'd2,
		LVL_DAY    = 3'd3,
		LVL_MONTH  = 3'd4,
		LVL_YEAR   = 3'd5,
		LVL_LOADED = 3'd6,
		LVL_REJECT = 3'd7
	} rcc_level_t;

	function automatic logic is_leap(input logic [6:0] year);
		return (year[1:0] == 2'd0);
	endfunction

	function automatic logic [4:0] month_length(input logic [3:0] month,
			input logic [6:0] year);
		if (month == 4'd2) begin
			return is_leap(year) ? 5'd29 : 5'd28;
		end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			return 5'd30;
		end else begin
			return 5'd31;
		end
	endfunction

	// days before the month, mod 7
	function automatic logic [2:0] month_offset(input logic [3:0] month,
			input logic leap);
		logic [2:0] off;
		case (month)
			4'd1:    off = 3'd0;
			4'd2:    off = 3'd3;
			4'd3:    off = leap ? 3'd4 : 3'd3;
			4'd4:    off = leap ? 3'd0 : 3'd6;
			4'd5:    off = leap ? 3'd2 : 3'd1;
			4'd6:    off = leap ? 3'd5 : 3'd4;
			4'd7:    off = leap ? 3'd0 : 3'd6;
			4'd8:    off = leap ? 3'd3 : 3'd2;
			4'd9:    off = leap ? 3'd6 : 3'd5;
			4'd10:   off = leap ? 3'd1 : 3'd0;
			4'd11:   off = leap ? 3'd4 : 3'd3;
			4'd12:   off = leap ? 3'd6 : 3'd5;
			default: off = 3'd0;
		endcase
		return off;
	endfunction

	// 8 = 1 mod 7: fold octal digits, then one correction
	function automatic logic [2:0] mod7(input logic [7:0] w);
		logic [4:0] s;
		logic [3:0] t;
		s = {2'b0, w[2:0]} + {2'b0, w[5:3]} + {3'b0, w[7:6]};
		t = {1'b0, s[2:0]} + {2'b0, s[4:3]};
		if (t >= 4'd7) begin
			t = t - 4'd7;
		end
		return t[2:0];
	endfunction

	// 2000-01-01 was a Saturday; 0 = Sunday
	function automatic logic [2:0] calc_weekday(input rcc_time_t t);
		logic [7:0] y8;
		logic [7:0] q;
		logic [7:0] w;
		y8 = {1'b0, t.year};
		q  = (y8 + 8'd3) >> 2;
		w  = y8 + q + {5'b0, month_offset(t.month, is_leap(t.year))}
			+ {3'b0, t.day} + 8'd12;
		return mod7(w);
	endfunction

endpackage

// ----- hdl/rcc_step.sv -----
module rcc_step (
	input  rcc_pkg::rcc_time_t  cur,
	input  logic                mode,
	input  rcc_pkg::rcc_time_t  set,
	output rcc_pkg::rcc_time_t  nxt,
	output rcc_pkg::rcc_level_t level,
	output logic [2:0]          weekday
);
	import rcc_pkg::*;

	logic set_ok;

	always_comb begin
		set_ok = (set.second <= SEC_MAX) && (set.minute <= MIN_MAX)
			&& (set.hour <= HOUR_MAX) && (set.year <= YEAR_MAX)
			&& (set.month != 4'd0) && (set.month <= MONTH_MAX)
			&& (set.day != 5'd0) && (set.day <= month_length(set.month, set.year));
	end

	always_comb begin
		nxt   = cur;
		level = LVL_SECOND;
		if (mode) begin
			if (set_ok) begin
				nxt   = set;
				level = LVL_LOADED;
			end else begin
				level = LVL_REJECT;
			end
		end else if (cur.second != SEC_MAX) begin
			nxt.second = cur.second + 6'd1;
		end else begin
			nxt.second = 6'd0;
			level      = LVL_MINUTE;
			if (cur.minute != MIN_MAX) begin
				nxt.minute = cur.minute + 6'd1;
			end else begin
				nxt.minute = 6'd0;
				level      = LVL_HOUR;
				if (cur.hour != HOUR_MAX) begin
					nxt.hour = cur.hour + 5'd1;
				end else begin
					nxt.hour = 5'd0;
					level    = LVL_DAY;
					if (cur.day != month_length(cur.month, cur.year)) begin
						nxt.day = cur.day + 5'd1;
					end else begin
						nxt.day = 5'd1;
						level   = LVL_MONTH;
						if (cur.month != MONTH_MAX) begin
							nxt.month = cur.month + 4'd1;
						end else begin
							nxt.month = 4'd1;
							level     = LVL_YEAR;
							nxt.year  = (cur.year == YEAR_MAX) ? 7'd0 : cur.year + 7'd1;
						end
					end
				end
			end
		end
	end

	assign weekday = calc_weekday(nxt);

endmodule

// ----- hdl/rtc_calendar_counter.sv -----
// Calendar clock for 2000..2099 (year 00..99), reset to Saturday 2000-01-01 00:00:00.
// Each request on the input stream is either a one-second tick (tuser = 0) or a time
// load (tuser = 1); every request returns exactly one result holding the time after
// the step, the weekday (0 = Sunday) and a status code: the highest field that
// advanced on a tick, 6 for an accepted load, or 7 for a rejected load, which leaves
// the time unchanged. One request is taken every cycle while the result stream does not
// stall; each result passes from the input register through the carry chain and weekday
// logic into the result register, and a stalled result stream holds the pipe.
module rtc_calendar_counter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// set_second, set_minute, set_hour, set_day, set_month, set_year, zero pad
	input  logic [rcc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// cur_second, cur_minute, cur_hour, cur_day, cur_month, cur_year, weekday,
	// carry_level, zero pad
	output logic [rcc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import rcc_pkg::*;

	localparam int TIME_W = $bits(rcc_time_t);

	localparam rcc_time_t TIME_RST = '{year: 7'd0, month: 4'd1, day: 5'd1,
		hour: 5'd0, minute: 6'd0, second: 6'd0};

	logic       valid_s1;
	logic       mode_s1;
	rcc_time_t  set_s1;
	rcc_time_t  time_q;
	logic       out_valid_q;
	rcc_time_t  out_time_q;
	logic [2:0] out_wday_q;
	rcc_level_t out_level_q;

	rcc_time_t  nxt_time;
	rcc_level_t nxt_level;
	logic [2:0] nxt_wday;
	logic       adv;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;

	rcc_step u_step (
		.cur     (time_q),
		.mode    (mode_s1),
		.set     (set_s1),
		.nxt     (nxt_time),
		.level   (nxt_level),
		.weekday (nxt_wday)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			time_q      <= TIME_RST;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					time_q <= nxt_time;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1 <= s_axis_tuser;
			set_s1  <= s_axis_tdata[TIME_W-1:0];
		end
		if (adv && valid_s1) begin
			out_time_q  <= nxt_time;
			out_wday_q  <= nxt_wday;
			out_level_q <= nxt_level;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - TIME_W - 6){1'b0}}, out_level_q, out_wday_q,
		out_time_q};

	a_time_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(time_q.second <= SEC_MAX) && (time_q.minute <= MIN_MAX)
		&& (time_q.hour <= HOUR_MAX) && (time_q.year <= YEAR_MAX)
		&& (time_q.month != 4'd0) && (time_q.month <= MONTH_MAX)
		&& (time_q.day != 5'd0) && (time_q.day <= month_length(time_q.month, time_q.year)))
		else $error("calendar state out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> $stable(time_q))
		else $error("time advanced while result stalled");

	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && (nxt_level == LVL_REJECT) |=> $stable(time_q))
		else $error("rejected load changed the time");

	a_result_time: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 |=> (out_time_q == time_q) && out_valid_q)
		else $error("result time differs from state");

endmodule
